// ----- hw/rtl/bsc_pkg.sv -----
// Shared types and constants for the barometric compensation core.
`default_nettype none
package bsc_pkg;

    typedef enum logic [1:0] {
        ALU_MUL = 2'b01,
        ALU_ADD = 2'b10
    } alu_op_t;

    typedef struct packed {
        logic              start;
        logic              sign;
        logic [31:0]       dividend;
        logic [31:0]       divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [31:0]       quotient;
    } div_rsp_t;

    localparam logic [2:0] CFG_AC123 = 3'd0;
    localparam logic [2:0] CFG_AC456 = 3'd1;
    localparam logic [2:0] CFG_B12   = 3'd2;
    localparam logic [2:0] CFG_MCMD  = 3'd3;
    localparam logic [2:0] CFG_OSS   = 3'd4;

    localparam logic signed [31:0] B6_OFFSET  = 32'sd4000;
    localparam logic [31:0]        X3_OFFSET  = 32'd32768;
    localparam logic [31:0]        B7_SCALE   = 32'd50000;
    localparam logic signed [31:0] P_K1       = 32'sd3038;
    localparam logic signed [31:0] P_K2       = -32'sd7357;
    localparam logic signed [31:0] P_K3       = 32'sd3791;

endpackage
`default_nettype wire

// ----- hw/rtl/bsc_div.sv -----
// Shared radix-2 restoring divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module bsc_div
    import bsc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [31:0] num_reg, num_next;
    logic [31:0] den_reg, den_next;
    logic [31:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, num_reg[31]};
        trial     = shifted - {1'b0, den_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd32;
            rem_next  = '0;
            if (req.sign)
            begin
                num_next = req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
                den_next = req.divisor[31] ? (32'd0 - req.divisor) : req.divisor;
                neg_next = req.dividend[31] ^ req.divisor[31];
            end
            else
            begin
                num_next = req.dividend;
                den_next = req.divisor;
                neg_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                num_next = {num_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                num_next = {num_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (32'd0 - num_reg) : num_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/barometric_sensor_compensation_core.sv -----
// Top level of the barometric compensation core: config, sequencer, shared multiplier and divider.
// Each word takes one pass of a microcoded sequence through a single registered 32x32
// multiplier and adder, plus one pass of the shared serial divider, which a zero divisor
// skips. A new word is accepted only once the previous result has been taken.
`default_nettype none
module barometric_sensor_compensation_core
    import bsc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // raw_value[23:0]
    input  wire logic        s_tuser,   // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // value[31:0]
    output logic [1:0]       m_tuser    // kind in bit 0, fault in bit 1
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_RUN  = 7'b0000010,
        ST_DIV  = 7'b0000100,
        ST_WAIT = 7'b0001000,
        ST_POST = 7'b0010000,
        ST_OUT  = 7'b0100000,
        ST_PRE  = 7'b1000000
    } state_t;

    state_t       state_reg, state_next;
    logic [47:0]  ac123_reg, ac456_reg;
    logic [31:0]  b12_reg, mcmd_reg;
    logic [1:0]   oss_reg;
    logic signed [31:0] b5_reg;
    logic         act_reg;
    logic [23:0]  raw_reg;
    logic [4:0]   step_reg, step_next;
    logic signed [31:0] r_reg [0:7];
    logic signed [31:0] res_reg;
    logic         fault_reg;
    logic signed [31:0] alu_a, alu_b, alu_y;
    alu_op_t      alu_op;
    logic [2:0]   alu_dst;
    logic         alu_en;
    div_req_t     dreq;
    div_rsp_t     drsp;
    logic signed [31:0] p_a, p_b;
    logic [2:0]         p_dst;
    logic               p_mul;

    logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [31:0]  ac4, ac5, ac6;

    assign ac1 = 32'(signed'(ac123_reg[47:32]));
    assign ac2 = 32'(signed'(ac123_reg[31:16]));
    assign ac3 = 32'(signed'(ac123_reg[15:0]));
    assign ac4 = {16'd0, ac456_reg[47:32]};
    assign ac5 = {16'd0, ac456_reg[31:16]};
    assign ac6 = {16'd0, ac456_reg[15:0]};
    assign b1  = 32'(signed'(b12_reg[31:16]));
    assign b2  = 32'(signed'(b12_reg[15:0]));
    assign mc  = 32'(signed'(mcmd_reg[31:16]));
    assign md  = 32'(signed'(mcmd_reg[15:0]));

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = res_reg;
    assign m_tuser   = {fault_reg, act_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac123_reg <= '0;
            ac456_reg <= '0;
            b12_reg   <= '0;
            mcmd_reg  <= '0;
            oss_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_AC123: ac123_reg <= cfg_data;
                CFG_AC456: ac456_reg <= cfg_data;
                CFG_B12:   b12_reg   <= cfg_data[31:0];
                CFG_MCMD:  mcmd_reg  <= cfg_data[31:0];
                CFG_OSS:   oss_reg   <= cfg_data[1:0];
                default:   ;
            endcase
        end
    end

    // Microcode: registers r0..r7; product of one step is registered before use.
    // Temperature: r0=(ut-ac6)*ac5>>>15 (x1); r1=x1+md (den); divide mc<<11 by den.
    // Pressure pre-divide: r0=b6, r1=sq, r2=b3, r3=b4(udiv), r4=b7.
    always_comb
    begin
        alu_en  = 1'b0;
        alu_op  = ALU_ADD;
        alu_a   = '0;
        alu_b   = '0;
        alu_dst = 3'd0;
        alu_y   = '0;
        if (!act_reg)
        begin
            case (step_reg)
                5'd0: begin alu_en = 1'b1; alu_op = ALU_MUL;
                      alu_a = $signed({16'd0, raw_reg[15:0]}) - $signed(ac6);
                      alu_b = ac5; alu_dst = 3'd7; end
                5'd1: begin alu_en = 1'b1; alu_a = r_reg[7] >>> 15; alu_b = '0;
                      alu_dst = 3'd0; end
                5'd2: begin alu_en = 1'b1; alu_a = r_reg[0]; alu_b = md; alu_dst = 3'd1; end
                default: ;
            endcase
        end
        else
        begin
            case (step_reg)
                5'd0:  begin alu_en = 1'b1; alu_a = b5_reg; alu_b = -B6_OFFSET;
                       alu_dst = 3'd0; end
                5'd1:  begin alu_en = 1'b1; alu_op = ALU_MUL; alu_a = r_reg[0];
                       alu_b = r_reg[0]; alu_dst = 3'd7; end
                5'd2:  begin alu_en = 1'b1; alu_a = r_reg[7] >>> 12; alu_dst = 3'd1; end
                5'd3:  begin alu_en = 1'b1; alu_op = ALU_MUL; alu_a = b2; alu_b = r_reg[1];
                       alu_dst = 3'd7; end
                5'd4:  begin alu_en = 1'b1; alu_a = r_reg[7] >>> 11; alu_dst = 3'd2; end
                5'd5:  begin alu_en = 1'b1; alu_op = ALU_MUL; alu_a = ac2; alu_b = r_reg[0];
                       alu_dst = 3'd7; end
                5'd6:  begin alu_en = 1'b1; alu_a = r_reg[2]; alu_b = r_reg[7] >>> 11;
                       alu_dst = 3'd2; end
                5'd7:  begin alu_en = 1'b1; alu_a = ac1 <<< 2; alu_b = r_reg[2];
                       alu_dst = 3'd2; end
                5'd8:  begin alu_en = 1'b1; alu_a = (r_reg[2] <<< oss_reg); alu_b = 32'sd2;
                       alu_dst = 3'd2; end
                5'd9:  begin alu_en = 1'b1; alu_a = r_reg[2] >>> 2; alu_dst = 3'd2; end
                5'd10: begin alu_en = 1'b1; alu_op = ALU_MUL; alu_a = ac3; alu_b = r_reg[0];
                       alu_dst = 3'd7; end
                5'd11: begin alu_en = 1'b1; alu_a = r_reg[7] >>> 13; alu_dst = 3'd3; end
                5'd12: begin alu_en = 1'b1; alu_op = ALU_MUL; alu_a = b1; alu_b = r_reg[1];
                       alu_dst = 3'd7; end
                5'd13: begin alu_en = 1'b1; alu_a = r_reg[3]; alu_b = r_reg[7] >>> 16;
                       alu_dst = 3'd3; end
                5'd14: begin alu_en = 1'b1; alu_a = r_reg[3]; alu_b = 32'sd2; alu_dst = 3'd3; end
                5'd15: begin alu_en = 1'b1; alu_a = (r_reg[3] >>> 2); alu_b = X3_OFFSET;
                       alu_dst = 3'd3; end
                5'd16: begin alu_en = 1'b1; alu_op = ALU_MUL; alu_a = ac4; alu_b = r_reg[3];
                       alu_dst = 3'd7; end
                5'd17: begin alu_en = 1'b1; alu_a = $signed({15'd0, r_reg[7][31:15]});
                       alu_dst = 3'd3; end
                5'd18: begin alu_en = 1'b1;
                       alu_a = $signed({8'd0, raw_reg} >> (4'd8 - {2'd0, oss_reg}));
                       alu_b = -r_reg[2]; alu_dst = 3'd4; end
                5'd19: begin alu_en = 1'b1; alu_op = ALU_MUL; alu_a = r_reg[4];
                       alu_b = $signed(B7_SCALE >> oss_reg); alu_dst = 3'd4; end
                default: ;
            endcase
        end
        if (state_reg == ST_POST)
        begin
            alu_a   = p_a;
            alu_b   = p_b;
            alu_op  = p_mul ? ALU_MUL : ALU_ADD;
            alu_dst = p_dst;
        end
        if (alu_op == ALU_MUL)
            alu_y = alu_a * alu_b;
        else
            alu_y = alu_a + alu_b;
    end

    // Post-divide pressure steps; their operands go through the same multiplier and adder.
    always_comb
    begin
        p_a = '0; p_b = '0; p_dst = 3'd0; p_mul = 1'b0;
        case (step_reg)
            5'd0: begin p_a = r_reg[5] >>> 8; p_b = r_reg[5] >>> 8; p_mul = 1'b1;
                  p_dst = 3'd7; end
            5'd1: begin p_a = r_reg[7]; p_b = P_K1; p_mul = 1'b1; p_dst = 3'd7; end
            5'd2: begin p_a = r_reg[7] >>> 16; p_dst = 3'd6; end
            5'd3: begin p_a = P_K2; p_b = r_reg[5]; p_mul = 1'b1; p_dst = 3'd7; end
            5'd4: begin p_a = r_reg[6]; p_b = r_reg[7] >>> 16; p_dst = 3'd6; end
            5'd5: begin p_a = r_reg[6]; p_b = P_K3; p_dst = 3'd6; end
            5'd6: begin p_a = r_reg[5]; p_b = r_reg[6] >>> 4; p_dst = 3'd6; end
            default: ;
        endcase
    end

    logic [31:0] b7u;
    assign b7u = r_reg[4];

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        dreq       = '0;
        case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            ST_RUN:
            begin
                step_next = step_reg + 5'd1;
                if ((!act_reg && step_reg == 5'd2) || (act_reg && step_reg == 5'd19))
                    state_next = ST_PRE;
            end
            ST_PRE:
            begin
                if (!act_reg ? (r_reg[1] == 32'sd0) : (r_reg[3] == 32'sd0))
                    state_next = ST_OUT;
                else
                begin
                    dreq.start = 1'b1;
                    if (!act_reg)
                    begin
                        dreq.sign     = 1'b1;
                        dreq.dividend = mc <<< 11;
                        dreq.divisor  = r_reg[1];
                    end
                    else
                    begin
                        dreq.sign     = 1'b0;
                        dreq.dividend = b7u[31] ? b7u : (b7u << 1);
                        dreq.divisor  = r_reg[3];
                    end
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
                state_next = ST_WAIT;
            ST_WAIT:
                if (drsp.done)
                begin
                    state_next = ST_POST;
                    step_next  = '0;
                end
            ST_POST:
            begin
                step_next = step_reg + 5'd1;
                if (!act_reg || step_reg == 5'd6)
                    state_next = ST_OUT;
            end
            ST_OUT:
                if (m_tready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    bsc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            b5_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (state_reg == ST_POST && !act_reg)
                b5_reg <= r_reg[0] + r_reg[5];
        end
    end

    logic [31:0] q_adj;
    assign q_adj = b7u[31] ? (drsp.quotient << 1) : drsp.quotient;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            act_reg <= s_tuser;
            raw_reg <= s_tdata;
        end
        if (state_reg == ST_RUN && alu_en)
            r_reg[alu_dst] <= alu_y;
        if (state_reg == ST_PRE)
        begin
            fault_reg <= 1'b1;
            res_reg   <= '0;
        end
        if (state_reg == ST_WAIT && drsp.done)
        begin
            fault_reg <= 1'b0;
            r_reg[5]  <= act_reg ? q_adj : drsp.quotient;
        end
        if (state_reg == ST_POST)
        begin
            if (!act_reg)
                res_reg <= (r_reg[0] + r_reg[5] + 32'sd8) >>> 4;
            else
            begin
                r_reg[alu_dst] <= alu_y;
                if (step_reg == 5'd6)
                    res_reg <= alu_y;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid && !drsp.busy)
        else $error("ready while busy");
    a_div_once: assert property (@(posedge clk) disable iff (!rst_n)
        dreq.start |-> !drsp.busy)
        else $error("divider restarted while busy");

endmodule
`default_nettype wire
